FILE: hw/rtl/utf8rd_pkg.sv
// Shared types and constants of the UTF-8 replacing decoder.
`default_nettype none

package utf8rd_pkg;

	// Bytes of the replacement sequence U+FFFD.
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// Code point limits.
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] MIN_LEN2    = 21'h000080;
	localparam logic [20:0] MIN_LEN3    = 21'h000800;
	localparam logic [20:0] MIN_LEN4    = 21'h010000;

	// Number of entries in the job queue.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One job describes all output bytes caused by one input item:
	// replacements up to rep_end, literal bytes up to lit_end, then
	// replacements up to total.
	typedef struct packed {
		logic [3:0]      rep_end;
		logic [3:0]      lit_end;
		logic [3:0]      total;
		logic [3:0][7:0] lit_bytes;
	} job_t;

	// Byte of the replacement sequence at position pos.
	function automatic logic [7:0] repl_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = REPL_B0;
			2'd1:    b = REPL_B1;
			default: b = REPL_B2;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utf8rd_front.sv
// Front part: accepts input items, tracks the open sequence and builds jobs.
`default_nettype none

module utf8rd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        in_byte,
	input  wire logic              end_of_input,
	input  wire logic              queue_full,
	output logic                   push,
	output utf8rd_pkg::job_t       push_job
);
	import utf8rd_pkg::*;

	logic [7:0]  held_q [3];
	logic [1:0]  held_count_q;
	logic [2:0]  seq_len_q;

	logic        accept;
	logic        open_seq;
	logic        is_cont;
	logic        take_start;
	logic        early;
	logic        is_ascii;
	logic [2:0]  lead_len;
	logic        bad_lead;
	logic        opens;
	logic        grow;
	logic        finish;
	logic [20:0] cp;
	logic [20:0] cp_min;
	logic        cp_bad;
	logic        rep_tail;
	logic [2:0]  rep_cnt;
	logic [2:0]  lit_n;
	logic [3:0]  rep_end;
	logic [3:0]  lit_end;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// Classification of the incoming byte against the open sequence.
	assign open_seq   = held_count_q != 2'd0;
	assign is_cont    = in_byte[7:6] == 2'b10;
	assign early      = open_seq && !is_cont;
	assign take_start = !open_seq || !is_cont;
	assign is_ascii   = !in_byte[7];

	always_comb begin
		case (in_byte) inside
			[8'hC2:8'hDF]: lead_len = 3'd2;
			[8'hE0:8'hEF]: lead_len = 3'd3;
			[8'hF0:8'hF4]: lead_len = 3'd4;
			default:       lead_len = 3'd0;
		endcase
	end

	assign bad_lead = !is_ascii && lead_len == 3'd0;
	assign opens    = take_start && lead_len != 3'd0;
	assign grow     = open_seq && is_cont && ({1'b0, held_count_q} + 3'd1 < seq_len_q);
	assign finish   = open_seq && is_cont && !grow;

	// Code point of the completed sequence and its validity.
	always_comb begin
		case (seq_len_q)
			3'd2: begin
				cp     = {10'd0, held_q[0][4:0], in_byte[5:0]};
				cp_min = MIN_LEN2;
			end
			3'd3: begin
				cp     = {5'd0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
				cp_min = MIN_LEN3;
			end
			default: begin
				cp     = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte[5:0]};
				cp_min = MIN_LEN4;
			end
		endcase
	end

	assign cp_bad = cp < cp_min || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI);

	// A sequence still open after the final byte gives one trailing replacement.
	assign rep_tail = end_of_input && (opens || grow);

	// Job layout for this item.
	always_comb begin
		rep_cnt = {2'd0, early} + {2'd0, take_start && bad_lead};
		if (finish && cp_bad) begin
			rep_cnt = seq_len_q;
		end
		lit_n = 3'd0;
		if (take_start && is_ascii) begin
			lit_n = 3'd1;
		end else if (finish && !cp_bad) begin
			lit_n = seq_len_q;
		end
	end

	assign rep_end = {1'b0, rep_cnt} + {rep_cnt, 1'b0};
	assign lit_end = rep_end + {1'b0, lit_n};

	always_comb begin
		push_job.rep_end      = rep_end;
		push_job.lit_end      = lit_end;
		push_job.total        = lit_end + (rep_tail ? 4'd3 : 4'd0);
		push_job.lit_bytes[0] = finish ? held_q[0] : in_byte;
		push_job.lit_bytes[1] = (seq_len_q > 3'd2) ? held_q[1] : in_byte;
		push_job.lit_bytes[2] = (seq_len_q > 3'd3) ? held_q[2] : in_byte;
		push_job.lit_bytes[3] = in_byte;
	end

	assign push = accept && push_job.total != 4'd0;

	// Sequence tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			seq_len_q    <= 3'd0;
		end else if (accept) begin
			if (end_of_input) begin
				held_count_q <= 2'd0;
				seq_len_q    <= 3'd0;
			end else if (opens) begin
				held_count_q <= 2'd1;
				seq_len_q    <= lead_len;
			end else if (grow) begin
				held_count_q <= held_count_q + 2'd1;
			end else begin
				held_count_q <= 2'd0;
				seq_len_q    <= 3'd0;
			end
		end
	end

	// Held bytes of the open sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (opens) begin
				held_q[0] <= in_byte;
			end else if (grow) begin
				held_q[held_count_q] <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/utf8rd_queue.sv
// Short job queue between the front and back parts.
`default_nettype none

module utf8rd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire utf8rd_pkg::job_t  push_job,
	output logic                   full,
	input  wire logic              pop,
	output logic                   nonempty,
	output utf8rd_pkg::job_t       head
);
	import utf8rd_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	// Storage of queued jobs.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/utf8rd_back.sv
// Back part: expands each job into output items through an output register.
`default_nettype none

module utf8rd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  wire utf8rd_pkg::job_t  job,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic                   run_last
);
	import utf8rd_pkg::*;

	logic [3:0] pos_q;
	logic [1:0] rep_pos_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	logic       load;
	logic       in_lit;
	logic [1:0] lit_off;
	logic       job_done;
	logic [7:0] next_byte;

	assign load = job_valid && (!out_valid_q || !out_stall);

	// Select the byte at the current position of the head job.
	assign in_lit    = pos_q >= job.rep_end && pos_q < job.lit_end;
	assign lit_off   = pos_q[1:0] - job.rep_end[1:0];
	assign next_byte = in_lit ? job.lit_bytes[lit_off] : repl_byte(rep_pos_q);
	assign job_done  = pos_q == job.total - 4'd1;
	assign pop       = load && job_done;

	// Walk through the head job, one output item per load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 4'd0;
			rep_pos_q <= 2'd0;
		end else if (load) begin
			if (job_done) begin
				pos_q     <= 4'd0;
				rep_pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 4'd1;
				if (!in_lit) begin
					rep_pos_q <= (rep_pos_q == 2'd2) ? 2'd0 : rep_pos_q + 2'd1;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_last_q <= job_done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_replacing_decoder.sv
// UTF-8 replacing decoder: checks a byte stream and replaces bad sequences by U+FFFD.
//
// Input channel in_valid / in_stall carries one raw byte (in_byte) per item,
// with end_of_input set on the final byte of a stream. Output channel
// out_valid / out_stall carries one sanitized byte (out_byte) per item;
// run_last marks the last output byte caused by a given input byte.
// Bytes of an open multi-byte sequence produce no output until it completes or
// is cut short. The front part classifies a byte and writes a job into a
// two-entry queue; the back part emits one output byte per cycle from it
// while out_stall is low. The first output byte of an input passes through
// the job queue and then the output register before it is offered on out_valid.
// Throughput: one input byte per cycle while each byte causes at most one
// output byte and out_stall is low; a byte that causes N output bytes (up to
// 12) holds the back part until all N are out; in_stall rises once the queue is full.
// When the receiver raises out_stall the output register holds its byte and
// the queue fills, then in_stall rises.
// Reset clears the open sequence, the queue and the output register.
`default_nettype none

module utf8_replacing_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last
);
	import utf8rd_pkg::*;

	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic nonempty;
	job_t head;

	// Front: classification and sequence tracking.
	utf8rd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.queue_full   (queue_full),
		.push         (push),
		.push_job     (push_job)
	);

	// Job queue.
	utf8rd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	// Back: output byte generation.
	utf8rd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (nonempty),
		.job       (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/utf8rd_checker.sv
// Port-level assertions for the UTF-8 replacing decoder and their binding.
`default_nettype none

module utf8rd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       end_of_input,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_last
);

	// Once reset has been sampled low, nothing is offered and nothing is stalled.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("output valid or input stall during reset");

	// A stalled output item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output item changed");

	// The last byte for an input item never opens a sequence.
	a_last_not_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> out_byte < 8'hC0)
		else $error("lead byte marked as last of an item");

	// A full queue means work is pending, so the output fills next cycle.
	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> out_valid)
		else $error("input stalled with no output offered");

endmodule

bind utf8_replacing_decoder utf8rd_checker u_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the UTF-8 replacing decoder.
`timescale 1ns / 100ps

module tb;
	import utf8rd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned PHASE_ITEMS  = 50;
	localparam int unsigned SETTLE_TICKS = 8;

	// One sanitized output byte as the block should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       last_of_run;
	} sanitized_byte_t;

	// Tracks the open sequence and the output bytes that are still owed.
	class utf8_output_tracker;
		logic [7:0]      seq_bytes [3];
		int unsigned     seq_count;
		int unsigned     seq_len;
		logic [7:0]      step_out [$];
		sanitized_byte_t owed_bytes [$];
		int unsigned     n_inputs;
		int unsigned     n_checked;
		int unsigned     n_errors;
		int unsigned     n_replacements;

		function void put_replacement();
			step_out = {step_out, REPL_B0};
			step_out = {step_out, REPL_B1};
			step_out = {step_out, REPL_B2};
			n_replacements++;
		endfunction

		// A byte seen with no open sequence: pass it, reject it, or open a sequence.
		function void open_or_pass(logic [7:0] b);
			int unsigned len;
			len = 0;
			if (b < 8'h80) begin
				step_out = {step_out, b};
				return;
			end
			if (b >= 8'hC2 && b <= 8'hDF) len = 2;
			else if (b >= 8'hE0 && b <= 8'hEF) len = 3;
			else if (b >= 8'hF0 && b <= 8'hF4) len = 4;
			if (len == 0) begin
				put_replacement();
				return;
			end
			seq_bytes[0] = b;
			seq_count = 1;
			seq_len = len;
		endfunction

		// The final continuation byte arrived: rebuild the code point and judge it.
		function void complete_sequence(logic [7:0] b);
			int unsigned cp;
			int unsigned floor_cp;
			int unsigned i;
			logic invalid;
			case (seq_len)
				2: begin
					cp = seq_bytes[0] & 8'h1F;
					floor_cp = MIN_LEN2;
				end
				3: begin
					cp = seq_bytes[0] & 8'h0F;
					floor_cp = MIN_LEN3;
				end
				default: begin
					cp = seq_bytes[0] & 8'h07;
					floor_cp = MIN_LEN4;
				end
			endcase
			for (i = 1; i < seq_len - 1; i++)
				cp = (cp << 6) | (seq_bytes[i] & 8'h3F);
			cp = (cp << 6) | (b & 8'h3F);
			invalid = cp < floor_cp || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI);
			if (invalid) begin
				repeat (seq_len) put_replacement();
			end else begin
				for (i = 0; i < seq_len - 1; i++)
					step_out = {step_out, seq_bytes[i]};
				step_out = {step_out, b};
			end
			seq_count = 0;
			seq_len = 0;
		endfunction

		// Works out the output bytes caused by one accepted input item.
		function void note_input(logic [7:0] b, logic eoi);
			sanitized_byte_t owed;
			step_out.delete();
			n_inputs++;
			if (seq_count == 0) begin
				open_or_pass(b);
			end else if (b[7:6] != 2'b10) begin
				// Early non-continuation byte: replace the open sequence, then start over.
				put_replacement();
				seq_count = 0;
				seq_len = 0;
				open_or_pass(b);
			end else if (seq_count + 1 < seq_len) begin
				seq_bytes[seq_count] = b;
				seq_count++;
			end else begin
				complete_sequence(b);
			end
			// A sequence cut short by the end of the stream gives one replacement.
			if (eoi) begin
				if (seq_count != 0) put_replacement();
				seq_count = 0;
				seq_len = 0;
			end
			foreach (step_out[i]) begin
				owed.data = step_out[i];
				owed.last_of_run = (i == step_out.size() - 1);
				owed_bytes = {owed_bytes, owed};
			end
		endfunction

		// Compares one accepted output byte with the oldest owed byte.
		function void check_result(logic [7:0] b, logic last);
			sanitized_byte_t want;
			n_checked++;
			if (owed_bytes.size() == 0) begin
				n_errors++;
				$display("%0t: output byte %02h (run_last %0b) arrived with nothing owed",
					$time, b, last);
				return;
			end
			want = owed_bytes.pop_front();
			if (b !== want.data) begin
				n_errors++;
				$display("%0t: out_byte expected %02h, got %02h", $time, want.data, b);
			end
			if (last !== want.last_of_run) begin
				n_errors++;
				$display("%0t: run_last expected %0b, got %0b", $time, want.last_of_run, last);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	utf8_output_tracker tracker;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned n_streams = 0;

	utf8_replacing_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last)
	);

	always #1 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Predict on every accepted input item.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall === 1'b0)
			tracker.note_input(in_byte, end_of_input);
	end

	// Check every accepted output item.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			tracker.check_result(out_byte, run_last);
	end

	// Offers one byte, with random idle cycles first, and waits until it is taken.
	task automatic push_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic send_stream(input logic [7:0] q [$]);
		foreach (q[i]) push_byte(q[i], i == q.size() - 1);
		n_streams++;
	endtask

	// Holds the sender off until every owed output byte has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed_bytes.size() != 0) @(posedge clk);
	endtask

	// Appends one random character, mostly well formed, sometimes broken.
	task automatic append_token(ref logic [7:0] q [$]);
		int unsigned pick;
		int unsigned cp;
		int unsigned n;
		logic [7:0] lead;
		pick = $urandom_range(99);
		if (pick < 25) begin
			q = {q, 8'($urandom_range(127))};
		end else if (pick < 45) begin
			cp = $urandom_range(32'h7FF, 32'h80);
			q = {q, 8'hC0 | 8'(cp >> 6)};
			q = {q, 8'h80 | 8'(cp & 32'h3F)};
		end else if (pick < 60) begin
			cp = $urandom_range(32'hFFFF, 32'h800);
			q = {q, 8'hE0 | 8'(cp >> 12)};
			q = {q, 8'h80 | 8'((cp >> 6) & 32'h3F)};
			q = {q, 8'h80 | 8'(cp & 32'h3F)};
		end else if (pick < 70) begin
			cp = $urandom_range(32'h10FFFF, 32'h10000);
			q = {q, 8'hF0 | 8'(cp >> 18)};
			q = {q, 8'h80 | 8'((cp >> 12) & 32'h3F)};
			q = {q, 8'h80 | 8'((cp >> 6) & 32'h3F)};
			q = {q, 8'h80 | 8'(cp & 32'h3F)};
		end else if (pick < 77) begin
			// Leads next to the overlong, surrogate and out-of-range borders.
			case ($urandom_range(3))
				0: lead = 8'hE0;
				1: lead = 8'hED;
				2: lead = 8'hF0;
				default: lead = 8'hF4;
			endcase
			n = (lead >= 8'hF0) ? 3 : 2;
			q = {q, lead};
			repeat (n) q = {q, 8'h80 | 8'($urandom_range(63))};
		end else if (pick < 86) begin
			// Sequence that stops before its last continuation byte.
			lead = 8'($urandom_range(8'hF4, 8'hC2));
			n = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
			q = {q, lead};
			repeat ($urandom_range(n - 1)) q = {q, 8'h80 | 8'($urandom_range(63))};
		end else if (pick < 93) begin
			case ($urandom_range(2))
				0: q = {q, 8'($urandom_range(8'hBF, 8'h80))};
				1: q = {q, 8'($urandom_range(8'hC1, 8'hC0))};
				default: q = {q, 8'($urandom_range(8'hFF, 8'hF5))};
			endcase
		end else begin
			q = {q, 8'($urandom_range(255))};
		end
	endtask

	// Sends random streams under one idling pattern, then lets the output drain.
	task automatic random_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
		logic [7:0] q [$];
		int unsigned sent;
		sender_idle_pct = snd_pct;
		receiver_idle_pct = rcv_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			q.delete();
			repeat ($urandom_range(6, 1)) append_token(q);
			send_stream(q);
			sent += q.size();
		end
		wait_drained();
	endtask

	initial begin
		logic [7:0] q [$];
		tracker = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, bad leads, valid and invalid code points, early end.
		q = '{8'h00, 8'hFF, 8'h80, 8'hC2, 8'h80, 8'hE0, 8'h80, 8'h80,
			8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC3, 8'h41};
		send_stream(q);
		q = '{8'hE2, 8'h82};
		send_stream(q);
		wait_drained();

		random_phase(36, 58);
		random_phase(58, 36);
		random_phase(0, 0);

		repeat (SETTLE_TICKS) @(posedge clk);
		$display("Sent %0d input bytes in %0d streams; checked %0d output bytes.",
			tracker.n_inputs, n_streams, tracker.n_checked);
		$display("Replacement sequences predicted: %0d; mismatches: %0d.",
			tracker.n_replacements, tracker.n_errors);
		if (tracker.n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/utf8rd_pkg.sv
hw/rtl/utf8rd_front.sv
hw/rtl/utf8rd_queue.sv
hw/rtl/utf8rd_back.sv
hw/rtl/utf8_replacing_decoder.sv
hw/rtl/utf8rd_checker.sv
test/tb.sv
